// ===== hdl/deq_pkg.sv =====
// Shared constants, action and status codes and transaction types of the double-ended queue.
package deq_pkg;

   // Ring depth; the count field of a response is sized to hold it.
   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int COUNT_W  = $clog2(CAPACITY + 1);

   localparam int ACTION_W = 3;
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 16;
   localparam int STATUS_W = 2;

   localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_READ       = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd4;

   localparam logic [STATUS_W-1:0] STS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STS_READ_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STS_PUSH_FULL  = 2'd2;

   typedef struct packed {
      logic [ACTION_W-1:0]        action;
      logic signed [VALUE_W-1:0]  value;
      logic signed [INDEX_W-1:0]  index;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]        status;
      logic signed [VALUE_W-1:0]  read_value;
      logic [COUNT_W-1:0]         count;
      logic                       is_empty;
   } rsp_type;

endpackage

// ===== hdl/double_ended_queue.sv =====
// Top level of the double-ended queue: ring buffer memory, pointers and response register.
//
//   Channel   Ports                    Direction  Handshake
//   request   start, busy, req_data    in         taken when start is high and busy is low
//   response  rsp_valid, rsp_data      out        one-cycle strobe, cannot be held off
//
// One transaction is taken per clock cycle while busy is low. Its response appears on the
// cycle after acceptance, for exactly one cycle; the read data comes from the registered
// read port of the ring memory. The synchronous reset clears the pointer, the count and
// the response strobe, and holds busy high for its duration. The ring memory itself is
// not cleared: only slots that a push has written are ever read. Busy never rises for any
// other reason, since the receiver cannot stall and no action needs a wait state.
module double_ended_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  deq_pkg::req_type req_data,
   output logic             rsp_valid,
   output deq_pkg::rsp_type rsp_data
);
   import deq_pkg::*;

   localparam int IDX_W = INDEX_W + 1;

   // Front pointer and entry count, the state that describes the queue contents.
   logic [ADDR_W-1:0]  front_ff, front_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               busy_ff;

   // Response register. Valid, status and the read select are control and are reset;
   // the read data is plain payload.
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rd_sel_ff, rd_sel_in;
   logic [VALUE_W-1:0]  rd_data_ff;

   // The ring storage, with one write port and one registered read port.
   logic [VALUE_W-1:0] ring_mem [CAPACITY];

   logic               accept;
   logic               full;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ADDR_W-1:0]  front_dec;
   logic [ADDR_W-1:0]  read_off;
   logic signed [IDX_W-1:0] idx_ext;
   logic signed [IDX_W-1:0] cnt_ext;
   logic signed [IDX_W-1:0] idx_adj;

   // Physical slot of a logical offset from the front, wrapping at the ring depth.
   function automatic logic [ADDR_W-1:0] ring_slot(input logic [ADDR_W-1:0] base,
                                                   input logic [ADDR_W-1:0] offset);
      logic [ADDR_W:0] sum;
      sum = {1'b0, base} + {1'b0, offset};
      if (sum >= (ADDR_W+1)'(CAPACITY)) begin
         sum = sum - (ADDR_W+1)'(CAPACITY);
      end
      return sum[ADDR_W-1:0];
   endfunction

   assign accept    = start && !busy_ff;
   assign full      = (count_ff >= COUNT_W'(CAPACITY));
   assign front_dec = (front_ff == '0) ? ADDR_W'(CAPACITY - 1) : front_ff - 1'b1;

   // An indexed read: a negative index counts back from the end, then the result is
   // clamped onto the first and last stored entries.
   always_comb begin
      idx_ext = IDX_W'(req_data.index);
      cnt_ext = signed'({{(IDX_W-COUNT_W){1'b0}}, count_ff});
      idx_adj = idx_ext;
      if (idx_ext < 0) begin
         idx_adj = idx_ext + cnt_ext;
      end
      if (idx_adj < 0) begin
         read_off = '0;
      end else if (idx_adj >= cnt_ext) begin
         read_off = ADDR_W'(count_ff - COUNT_W'(1));
      end else begin
         read_off = idx_adj[ADDR_W-1:0];
      end
      rd_addr = ring_slot(front_ff, read_off);
   end

   // Action decode: pointer and count updates, memory write and response status.
   always_comb begin
      front_in      = front_ff;
      count_in      = count_ff;
      wr_en         = 1'b0;
      wr_addr       = ring_slot(front_ff, count_ff[ADDR_W-1:0]);
      rsp_status_in = STS_OK;
      rd_sel_in     = 1'b0;
      if (accept) begin
         case (req_data.action)
            ACT_PUSH_BACK: begin
               if (full) begin
                  rsp_status_in = STS_PUSH_FULL;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            ACT_PUSH_FRONT: begin
               if (full) begin
                  rsp_status_in = STS_PUSH_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = front_dec;
                  front_in = front_dec;
                  count_in = count_ff + 1'b1;
               end
            end
            ACT_POP_BACK: begin
               if (count_ff != '0) begin
                  count_in = count_ff - 1'b1;
               end
            end
            ACT_READ: begin
               if (count_ff == '0) begin
                  rsp_status_in = STS_READ_EMPTY;
               end else begin
                  rd_sel_in = 1'b1;
               end
            end
            ACT_CLEAR: begin
               count_in = '0;
               front_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // The memory is written at the acceptance edge and read at the same edge; a read is
   // always accepted after any write it depends on, so no bypass is needed.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= req_data.value;
      end
      rd_data_ff <= ring_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff      <= '0;
         count_ff      <= '0;
         busy_ff       <= 1'b1;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= STS_OK;
         rd_sel_ff     <= 1'b0;
      end else begin
         front_ff      <= front_in;
         count_ff      <= count_in;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= accept;
         rsp_status_ff <= rsp_status_in;
         rd_sel_ff     <= rd_sel_in;
      end
   end

   assign busy                = busy_ff;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data.status     = rsp_status_ff;
   assign rsp_data.read_value = rd_sel_ff ? signed'(rd_data_ff) : '0;
   assign rsp_data.count      = count_ff;
   assign rsp_data.is_empty   = (count_ff == '0);

   // The entry count can never pass the ring depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   // Every accepted transaction produces exactly one response on the following cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted transaction without response");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_valid_ff)
      else $error("response without transaction");

   // A dropped push is only reported when the ring is really full.
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == STS_PUSH_FULL) |-> count_ff == COUNT_W'(CAPACITY))
      else $error("push reported full on a ring with room");

   // A successful push grows the queue by exactly one entry.
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      accept && !full && (req_data.action == ACT_PUSH_BACK ||
                          req_data.action == ACT_PUSH_FRONT)
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("push did not add one entry");

endmodule
